[hdl/year_tagged_day_bitmap_set_defines.svh]
// Assertion macros shared by the year-tagged day bitmap set RTL
`ifndef YEAR_TAGGED_DAY_BITMAP_SET_DEFINES_SVH
`define YEAR_TAGGED_DAY_BITMAP_SET_DEFINES_SVH

// Same-cycle check: when ante holds, cons must hold too
`define YTDB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check: when ante holds, cons must hold in the next cycle
`define YTDB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ytdb_pkg.sv]
// Types, constants and helper functions for the year-tagged day bitmap set
package ytdb_pkg;

  localparam int DAYS_PER_YEAR  = 366;
  localparam int WORDS_PER_SLOT = 6;
  localparam int WORD_W         = 64;
  localparam int YEAR_W         = 14;
  localparam int DAY_W          = 9;
  localparam int CNT_W          = 12;
  localparam int WSEL_W         = 3;

  // only bits 0..45 of the last word map to days 320..365
  localparam logic [WORD_W-1:0] LAST_WORD_MASK = 64'h0000_3FFF_FFFF_FFFF;
  localparam logic [CNT_W-1:0]  COUNT_MAX      = 12'hFFF;
  localparam logic [WSEL_W-1:0] LAST_WORD      = 3'd5;

  typedef enum logic [2:0] {
    OP_SET       = 3'd0,
    OP_CLEAR     = 3'd1,
    OP_TEST      = 3'd2,
    OP_FIRST     = 3'd3,
    OP_LAST      = 3'd4,
    OP_COUNT     = 3'd5,
    OP_CLEAR_ALL = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } stat_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SLOT,
    S_ACC_RD,
    S_ACC_EX,
    S_CHK_RD,
    S_CHK_EX,
    S_FIND_RD,
    S_FIND_EX,
    S_BYTE,
    S_CNT_RD,
    S_CNT_EX
  } state_e;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [YEAR_W-1:0] year;
    logic [DAY_W-1:0]  day_index;
  } in_item_t;

  typedef struct packed {
    logic              active;
    logic [1:0]        status;
    logic [YEAR_W-1:0] found_year;
    logic [DAY_W-1:0]  found_day;
    logic [CNT_W-1:0]  active_count;
  } out_item_t;

  // word store command bits
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr_slot;
    logic clr_all;
  } ws_cmd_t;

  function automatic logic [3:0] popcnt8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) n = n + 4'(v[i]);
    return n;
  endfunction

  function automatic logic [6:0] popcnt64(input logic [WORD_W-1:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) n = n + 7'(popcnt8(v[i*8 +: 8]));
    return n;
  endfunction

  // lowest set bit position of a byte
  function automatic logic [2:0] lsb8(input logic [7:0] v);
    logic [2:0] p;
    p = '0;
    for (int i = 7; i >= 0; i--) if (v[i]) p = 3'(i);
    return p;
  endfunction

  // highest set bit position of a byte
  function automatic logic [2:0] msb8(input logic [7:0] v);
    logic [2:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) if (v[i]) p = 3'(i);
    return p;
  endfunction

endpackage

[hdl/ytdb_word_store.sv]
// Day bitmap word memory with per-word valid bits (unwritten words read as zero)
module ytdb_word_store
  import ytdb_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  ws_cmd_t                                      cmd,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] clr_slot_idx,
  input  logic [$clog2(SLOTS*WORDS_PER_SLOT)-1:0]      wr_addr,
  input  logic [WORD_W-1:0]                            wr_data,
  input  logic [$clog2(SLOTS*WORDS_PER_SLOT)-1:0]      rd_addr,
  output logic [WORD_W-1:0]                            rd_data
);

  localparam int DEPTH  = SLOTS * WORDS_PER_SLOT;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  wvld_r;
  logic [WORD_W-1:0] rd_word_r;
  logic              rd_vld_r;
  logic [ADDR_W-1:0] slot_base;

  assign slot_base = ADDR_W'(clr_slot_idx) * ADDR_W'(WORDS_PER_SLOT);

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_word_r <= mem[rd_addr];
      rd_vld_r  <= wvld_r[rd_addr];
    end
  end

  // word valid bits: cleared per slot on claim, all at once on clear all
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r <= '0;
    end else if (cmd.clr_all) begin
      wvld_r <= '0;
    end else begin
      if (cmd.clr_slot) begin
        for (int w = 0; w < WORDS_PER_SLOT; w++) begin
          wvld_r[ADDR_W'(slot_base + ADDR_W'(w))] <= 1'b0;
        end
      end
      if (cmd.wr) begin
        wvld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_word_r : '0;

endmodule

[hdl/year_tagged_day_bitmap_set.sv]
// Top level of the year-tagged day bitmap set: slot table, sequencer, word store
//
//   channel  ports                      handshake
//   input    start, busy, in_item       taken when start && !busy
//   result   out_valid, out_item        one-cycle strobe, no backpressure
//
// Slot lookup walks the slot table one slot per cycle.
// Word accesses go through one word store: each word is read in a read state and
// used in the examine state after it. Count reads every word of every slot; clear
// all and opcode 7 are answered straight from idle. A new item can be taken at the
// result edge. Reset empties the table at once; the result strobe cannot be stalled.
`include "year_tagged_day_bitmap_set_defines.svh"

module year_tagged_day_bitmap_set
  import ytdb_pkg::*;
#(
  parameter int YEAR_SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int SLOT_W = (YEAR_SLOTS > 1) ? $clog2(YEAR_SLOTS) : 1;
  localparam int DEPTH  = YEAR_SLOTS * WORDS_PER_SLOT;
  localparam int ADDR_W = $clog2(DEPTH);

  state_e            state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              match_hit_r, match_hit_nxt;
  logic [SLOT_W-1:0] match_idx_r, match_idx_nxt;
  logic              free_hit_r, free_hit_nxt;
  logic [SLOT_W-1:0] free_idx_r, free_idx_nxt;
  logic              best_hit_r, best_hit_nxt;
  logic [SLOT_W-1:0] best_idx_r, best_idx_nxt;
  logic [YEAR_W-1:0] best_year_r, best_year_nxt;
  logic [SLOT_W-1:0] sel_r, sel_nxt;
  logic [WSEL_W-1:0] wsel_r, wsel_nxt;
  logic [2:0]        chunk_r, chunk_nxt;
  logic [WORD_W-1:0] fword_r, fword_nxt;
  logic [CNT_W-1:0]  acc_r, acc_nxt;
  logic [YEAR_SLOTS-1:0] slot_valid_r, slot_valid_nxt;
  logic [YEAR_W-1:0] slot_year_r [YEAR_SLOTS];
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              yr_we;
  ws_cmd_t           ws_cmd;
  logic [ADDR_W-1:0] ws_rd_addr;
  logic [ADDR_W-1:0] ws_wr_addr;
  logic [WORD_W-1:0] ws_wr_data;
  logic [WORD_W-1:0] ws_rd_data;

  function automatic logic [ADDR_W-1:0] waddr(input logic [SLOT_W-1:0] slot,
                                               input logic [WSEL_W-1:0] w);
    return ADDR_W'(slot) * ADDR_W'(WORDS_PER_SLOT) + ADDR_W'(w);
  endfunction

  ytdb_word_store #(
    .SLOTS (YEAR_SLOTS)
  ) u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (ws_cmd),
    .clr_slot_idx (sel_nxt),
    .wr_addr      (ws_wr_addr),
    .wr_data      (ws_wr_data),
    .rd_addr      (ws_rd_addr),
    .rd_data      (ws_rd_data)
  );

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_valid_r <= slot_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    idx_r       <= idx_nxt;
    match_hit_r <= match_hit_nxt;
    match_idx_r <= match_idx_nxt;
    free_hit_r  <= free_hit_nxt;
    free_idx_r  <= free_idx_nxt;
    best_hit_r  <= best_hit_nxt;
    best_idx_r  <= best_idx_nxt;
    best_year_r <= best_year_nxt;
    sel_r       <= sel_nxt;
    wsel_r      <= wsel_nxt;
    chunk_r     <= chunk_nxt;
    fword_r     <= fword_nxt;
    acc_r       <= acc_nxt;
    out_r       <= out_nxt;
  end

  // year tags, written when a free slot is claimed
  always_ff @(posedge clk) begin
    if (yr_we) begin
      slot_year_r[sel_nxt] <= item_r.year;
    end
  end

  // sequencer
  always_comb begin
    logic              day_ok;
    logic [WORD_W-1:0] bit_mask;
    logic [WSEL_W-1:0] day_word;
    logic              cur_valid;
    logic [YEAR_W-1:0] cur_year;
    logic              last_idx;
    logic              is_first;
    logic              done;
    out_item_t         res;
    logic [WORD_W-1:0] fw;
    logic [7:0]        byte_v;
    logic [CNT_W:0]    sum;

    day_ok    = item_r.day_index < DAY_W'(DAYS_PER_YEAR);
    bit_mask  = WORD_W'(1) << item_r.day_index[5:0];
    day_word  = item_r.day_index[DAY_W-1:6];
    cur_valid = slot_valid_r[idx_r];
    cur_year  = slot_year_r[idx_r];
    last_idx  = idx_r == SLOT_W'(YEAR_SLOTS - 1);
    is_first  = item_r.opcode == OP_FIRST;
    done      = 1'b0;
    res       = '0;
    fw        = ws_rd_data & ((wsel_r == LAST_WORD) ? LAST_WORD_MASK : '1);
    byte_v    = fword_r[{chunk_r, 3'b000} +: 8];
    sum       = {1'b0, acc_r}
              + (CNT_W + 1)'(popcnt64(fw & {WORD_W{slot_valid_r[idx_r]}}));

    state_nxt      = state_r;
    item_nxt       = item_r;
    idx_nxt        = idx_r;
    match_hit_nxt  = match_hit_r;
    match_idx_nxt  = match_idx_r;
    free_hit_nxt   = free_hit_r;
    free_idx_nxt   = free_idx_r;
    best_hit_nxt   = best_hit_r;
    best_idx_nxt   = best_idx_r;
    best_year_nxt  = best_year_r;
    sel_nxt        = sel_r;
    wsel_nxt       = wsel_r;
    chunk_nxt      = chunk_r;
    fword_nxt      = fword_r;
    acc_nxt        = acc_r;
    slot_valid_nxt = slot_valid_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    yr_we          = 1'b0;
    ws_cmd         = '0;
    ws_rd_addr     = waddr(sel_r, wsel_r);
    ws_wr_addr     = waddr(sel_r, day_word);
    ws_wr_data     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt      = in_item;
          idx_nxt       = '0;
          wsel_nxt      = '0;
          acc_nxt       = '0;
          match_hit_nxt = 1'b0;
          free_hit_nxt  = 1'b0;
          best_hit_nxt  = 1'b0;
          unique case (in_item.opcode) inside
            OP_CLEAR_ALL: begin
              ws_cmd.clr_all = 1'b1;
              slot_valid_nxt = '0;
              done           = 1'b1;
            end
            OP_COUNT: begin
              state_nxt = S_CNT_RD;
            end
            OP_SET, OP_CLEAR, OP_TEST, OP_FIRST, OP_LAST: begin
              state_nxt = S_SLOT;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      // one slot per cycle: tag match, first free slot, smallest/largest tag
      S_SLOT: begin
        if (!match_hit_r && cur_valid && cur_year == item_r.year) begin
          match_hit_nxt = 1'b1;
          match_idx_nxt = idx_r;
        end
        if (!free_hit_r && !cur_valid) begin
          free_hit_nxt = 1'b1;
          free_idx_nxt = idx_r;
        end
        if (cur_valid && (!best_hit_r || (is_first && cur_year < best_year_r) ||
            (!is_first && cur_year > best_year_r))) begin
          best_hit_nxt  = 1'b1;
          best_idx_nxt  = idx_r;
          best_year_nxt = cur_year;
        end
        if (!last_idx) begin
          idx_nxt = SLOT_W'(idx_r + 1'b1);
        end else begin
          unique case (item_r.opcode) inside
            OP_SET: begin
              if (!day_ok) begin
                done = 1'b1;
              end else if (match_hit_nxt) begin
                sel_nxt   = match_idx_nxt;
                state_nxt = S_ACC_RD;
              end else if (free_hit_nxt) begin
                // claim the free slot: tag it and blank its bitmap
                sel_nxt                      = free_idx_nxt;
                slot_valid_nxt[free_idx_nxt] = 1'b1;
                yr_we                        = 1'b1;
                ws_cmd.clr_slot              = 1'b1;
                state_nxt                    = S_ACC_RD;
              end else begin
                res.status = STAT_FULL;
                done       = 1'b1;
              end
            end
            OP_CLEAR, OP_TEST: begin
              if (day_ok && match_hit_nxt) begin
                sel_nxt   = match_idx_nxt;
                state_nxt = S_ACC_RD;
              end else begin
                done = 1'b1;
              end
            end
            OP_FIRST, OP_LAST: begin
              if (best_hit_nxt) begin
                sel_nxt   = best_idx_nxt;
                wsel_nxt  = is_first ? '0 : LAST_WORD;
                state_nxt = S_FIND_RD;
              end else begin
                res.status = STAT_NONE;
                done       = 1'b1;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      S_ACC_RD: begin
        ws_cmd.rd  = 1'b1;
        ws_rd_addr = waddr(sel_r, day_word);
        state_nxt  = S_ACC_EX;
      end

      // read-modify-write of the addressed word, or the test bit
      S_ACC_EX: begin
        if (item_r.opcode == OP_SET) begin
          ws_cmd.wr  = 1'b1;
          ws_wr_data = ws_rd_data | bit_mask;
          done       = 1'b1;
        end else if (item_r.opcode == OP_CLEAR) begin
          ws_cmd.wr  = 1'b1;
          ws_wr_data = ws_rd_data & ~bit_mask;
          wsel_nxt   = '0;
          state_nxt  = S_CHK_RD;
        end else begin
          res.active = |(ws_rd_data & bit_mask);
          done       = 1'b1;
        end
      end

      S_CHK_RD: begin
        ws_cmd.rd = 1'b1;
        state_nxt = S_CHK_EX;
      end

      // free the slot once every word reads empty
      S_CHK_EX: begin
        if (|ws_rd_data) begin
          done = 1'b1;
        end else if (wsel_r == LAST_WORD) begin
          slot_valid_nxt[sel_r] = 1'b0;
          done                  = 1'b1;
        end else begin
          wsel_nxt  = wsel_r + 1'b1;
          state_nxt = S_CHK_RD;
        end
      end

      S_FIND_RD: begin
        ws_cmd.rd = 1'b1;
        state_nxt = S_FIND_EX;
      end

      // find the first nonempty word, in scan direction
      S_FIND_EX: begin
        if (|fw) begin
          fword_nxt = fw;
          chunk_nxt = is_first ? 3'd0 : 3'd7;
          state_nxt = S_BYTE;
        end else if (is_first ? (wsel_r == LAST_WORD) : (wsel_r == '0)) begin
          res.status = STAT_NONE;
          done       = 1'b1;
        end else begin
          wsel_nxt  = is_first ? wsel_r + 1'b1 : wsel_r - 1'b1;
          state_nxt = S_FIND_RD;
        end
      end

      // narrow to a byte, then encode the bit within it
      S_BYTE: begin
        if (|byte_v) begin
          res.found_year = best_year_r;
          res.found_day  = {wsel_r, chunk_r, is_first ? lsb8(byte_v) : msb8(byte_v)};
          done           = 1'b1;
        end else begin
          chunk_nxt = is_first ? chunk_r + 1'b1 : chunk_r - 1'b1;
        end
      end

      S_CNT_RD: begin
        ws_cmd.rd  = 1'b1;
        ws_rd_addr = waddr(idx_r, wsel_r);
        state_nxt  = S_CNT_EX;
      end

      // saturating popcount accumulate over all words of valid slots
      S_CNT_EX: begin
        acc_nxt   = (sum > (CNT_W + 1)'(COUNT_MAX)) ? COUNT_MAX : sum[CNT_W-1:0];
        state_nxt = S_CNT_RD;
        if (wsel_r == LAST_WORD) begin
          wsel_nxt = '0;
          if (last_idx) begin
            res.active_count = acc_nxt;
            done             = 1'b1;
          end else begin
            idx_nxt = SLOT_W'(idx_r + 1'b1);
          end
        end else begin
          wsel_nxt = wsel_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
      state_nxt     = S_IDLE;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `YTDB_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid,
    "accepted item neither in work nor answered")
  `YTDB_ASSERT_NOW(a_result_when_idle, out_valid, !busy,
    "result strobe while the sequencer is still working")
  `YTDB_ASSERT_NOW(a_full_only_when_full, out_valid && out_item.status == STAT_FULL,
    &slot_valid_r, "table full reported with a free slot")
  `YTDB_ASSERT_NOW(a_store_port_exclusive, ws_cmd.rd, !ws_cmd.wr,
    "word store read and write in the same cycle")

endmodule

[tb/sv/year_tagged_day_bitmap_set_tb.sv]
// Self-checking testbench for the year-tagged day bitmap set
`timescale 1ns / 1ps

module year_tagged_day_bitmap_set_tb
  import ytdb_pkg::*;
();

  // Tracks the expected date set and checks each result against it in order
  class date_set_scoreboard #(int SLOTS = 8);
    bit                slot_used[SLOTS];
    logic [YEAR_W-1:0] slot_tag[SLOTS];
    logic [365:0]      slot_days[SLOTS];
    out_item_t         expected_q[$];
    int                n_mismatch;
    int                n_items;
    int                n_full;
    int                n_none;
    int                n_hits;

    function new();
      for (int s = 0; s < SLOTS; s++) begin
        slot_used[s] = 1'b0;
        slot_tag[s]  = '0;
        slot_days[s] = '0;
      end
      n_mismatch = 0;
      n_items    = 0;
      n_full     = 0;
      n_none     = 0;
      n_hits     = 0;
    endfunction

    // Applies one item to the tracked set and returns the result it should give
    function out_item_t apply_date_op(in_item_t it);
      out_item_t r;
      int        hit;
      int        best;
      int        total;
      bit        found;
      int        p;
      r   = '0;
      hit = -1;
      for (int s = 0; s < SLOTS; s++) begin
        if (slot_used[s] && slot_tag[s] == it.year) hit = s;
      end
      case (it.opcode) inside
        OP_SET: begin
          if (it.day_index < DAYS_PER_YEAR) begin
            // claim the lowest free slot for a new year
            if (hit < 0) begin
              for (int s = SLOTS - 1; s >= 0; s--) begin
                if (!slot_used[s]) hit = s;
              end
              if (hit >= 0) begin
                slot_used[hit] = 1'b1;
                slot_tag[hit]  = it.year;
                slot_days[hit] = '0;
              end
            end
            if (hit < 0) r.status = STAT_FULL;
            else slot_days[hit][it.day_index] = 1'b1;
          end
        end
        OP_CLEAR: begin
          if (it.day_index < DAYS_PER_YEAR && hit >= 0) begin
            slot_days[hit][it.day_index] = 1'b0;
            if (slot_days[hit] == '0) slot_used[hit] = 1'b0;
          end
        end
        OP_TEST: begin
          if (it.day_index < DAYS_PER_YEAR && hit >= 0)
            r.active = slot_days[hit][it.day_index];
        end
        OP_FIRST, OP_LAST: begin
          // pick the smallest or largest year tag, then scan its days
          best = -1;
          for (int s = 0; s < SLOTS; s++) begin
            if (slot_used[s]) begin
              if (best < 0 ||
                  (it.opcode == OP_FIRST && slot_tag[s] < slot_tag[best]) ||
                  (it.opcode == OP_LAST && slot_tag[s] > slot_tag[best]))
                best = s;
            end
          end
          r.status = STAT_NONE;
          found    = 1'b0;
          if (best >= 0) begin
            for (int d = 0; d < DAYS_PER_YEAR; d++) begin
              p = (it.opcode == OP_FIRST) ? d : DAYS_PER_YEAR - 1 - d;
              if (!found && slot_days[best][p]) begin
                found        = 1'b1;
                r.status     = STAT_OK;
                r.found_year = slot_tag[best];
                r.found_day  = DAY_W'(p);
              end
            end
          end
        end
        OP_COUNT: begin
          total = 0;
          for (int s = 0; s < SLOTS; s++) begin
            if (slot_used[s]) total += $countones(slot_days[s]);
          end
          r.active_count = (total > int'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(total);
        end
        OP_CLEAR_ALL: begin
          for (int s = 0; s < SLOTS; s++) begin
            slot_used[s] = 1'b0;
            slot_days[s] = '0;
          end
        end
        default: begin
          // unused opcode: no change, all-zero result
        end
      endcase
      return r;
    endfunction

    // Called for each accepted input item
    function void note_item(in_item_t it);
      out_item_t r;
      r = apply_date_op(it);
      n_items++;
      if (r.status == STAT_FULL) n_full++;
      if (r.status == STAT_NONE) n_none++;
      if (r.active) n_hits++;
      expected_q = {expected_q, r};
    endfunction

    // Called for each result strobe
    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $write("ERROR: result with nothing expected:");
          $display(" active=%0b status=%0d year=%0d day=%0d count=%0d",
                   got.active, got.status, got.found_year, got.found_day,
                   got.active_count);
        end
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.active !== exp_r.active || got.status !== exp_r.status ||
          got.found_year !== exp_r.found_year || got.found_day !== exp_r.found_day ||
          got.active_count !== exp_r.active_count) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $write("ERROR: mismatch: expected active=%0b status=%0d year=%0d day=%0d count=%0d,",
                 exp_r.active, exp_r.status, exp_r.found_year, exp_r.found_day,
                 exp_r.active_count);
          $display(" got active=%0b status=%0d year=%0d day=%0d count=%0d",
                   got.active, got.status, got.found_year, got.found_day,
                   got.active_count);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  localparam int SLOTS = 8;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int ITEMS_PER_PHASE = 475;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 150;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  date_set_scoreboard #(SLOTS) sb;
  logic [YEAR_W-1:0] year_pool[11];
  int drain_cycles;

  year_tagged_day_bitmap_set #(.YEAR_SLOTS(SLOTS)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial sb = new();

  // Watch both channels; results are checked before a new item is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_item);
      if (start && !busy) sb.note_item(in_item);
    end
  end

  // Drives one item; entered and left just after a falling edge
  task automatic send_item(input logic [2:0] op, input logic [YEAR_W-1:0] yr,
                           input logic [DAY_W-1:0] d, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start             = 1'b1;
    in_item.opcode    = op;
    in_item.year      = yr;
    in_item.day_index = d;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Word-edge and year-end days, so clears often empty a slot; else days 0..511
  function automatic logic [DAY_W-1:0] pick_day();
    logic [DAY_W-1:0] edge_days[12];
    int r;
    edge_days = '{0, 1, 63, 64, 127, 128, 255, 256, 319, 320, 364, 365};
    r = $urandom_range(99);
    if (r < 45) return edge_days[$urandom_range(11)];
    if (r < 93) return DAY_W'($urandom_range(365));
    return DAY_W'($urandom_range(511, 366));
  endfunction

  function automatic logic [YEAR_W-1:0] pick_year();
    if ($urandom_range(99) < 95) return year_pool[$urandom_range(10)];
    return YEAR_W'($urandom_range(16383));
  endfunction

  // Random item, weighted toward set and clear on a small pool of years
  task automatic send_random(input int idle_pct);
    int r;
    logic [2:0] op;
    r = $urandom_range(99);
    if (r < 30)      op = OP_SET;
    else if (r < 55) op = OP_CLEAR;
    else if (r < 70) op = OP_TEST;
    else if (r < 78) op = OP_FIRST;
    else if (r < 86) op = OP_LAST;
    else if (r < 94) op = OP_COUNT;
    else if (r < 96) op = OP_CLEAR_ALL;
    else if (r < 98) op = OP_UNUSED;
    else begin
      // raw noise over every field bit
      send_item(3'($urandom_range(7)), YEAR_W'($urandom_range(16383)),
                DAY_W'($urandom_range(511)), idle_pct);
      return;
    end
    send_item(op, pick_year(), pick_day(), idle_pct);
  endtask

  initial begin
    int idle_pct;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, extreme years and days, out-of-range days, full table
    send_item(OP_FIRST, 14'd0, 9'd0, 0);
    send_item(OP_LAST, 14'd0, 9'd0, 0);
    send_item(OP_COUNT, 14'd0, 9'd0, 0);
    send_item(OP_CLEAR, 14'd2000, 9'd10, 0);
    send_item(OP_SET, 14'd1400, 9'd0, 0);
    send_item(OP_SET, 14'd9999, 9'd365, 0);
    send_item(OP_SET, 14'd2024, 9'd59, 0);
    send_item(OP_TEST, 14'd1400, 9'd0, 0);
    send_item(OP_FIRST, 14'd0, 9'd0, 0);
    send_item(OP_SET, 14'd2024, 9'd400, 0);
    send_item(OP_TEST, 14'd2024, 9'd511, 0);
    send_item(OP_CLEAR, 14'd2024, 9'd59, 0);
    send_item(OP_SET, 14'd16383, 9'd100, 0);
    send_item(OP_SET, 14'd0, 9'd1, 0);
    send_item(OP_FIRST, 14'd0, 9'd0, 0);
    send_item(OP_LAST, 14'd0, 9'd0, 0);
    for (int i = 0; i < 5; i++) send_item(OP_SET, YEAR_W'(3000 + i), 9'd7, 0);
    send_item(OP_COUNT, 14'd0, 9'd0, 0);
    send_item(OP_UNUSED, 14'd9999, 9'd365, 0);
    send_item(OP_CLEAR_ALL, 14'd0, 9'd0, 0);
    send_item(OP_COUNT, 14'd0, 9'd0, 0);

    // Random phases: no idling, heavy sender gaps, no idling, light sender gaps
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 67 : (ph == 3) ? 34 : 0;
      for (int k = 0; k < 11; k++) year_pool[k] = YEAR_W'($urandom_range(9999, 1400));
      year_pool[10] = YEAR_W'($urandom_range(16383));
      repeat (ITEMS_PER_PHASE) send_random(idle_pct);
    end
    start = 1'b0;

    // Drain outstanding results, then watch for strays
    drain_cycles = 0;
    while (sb.pending() != 0) begin
      @(posedge clk);
      drain_cycles++;
      if (drain_cycles > DRAIN_LIMIT) begin
        $display("ERROR: %0d results never arrived", sb.pending());
        $display("Verification failed");
        $finish;
      end
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d items: %0d table-full sets, %0d empty searches, %0d test hits",
             sb.n_items, sb.n_full, sb.n_none, sb.n_hits);
    $display("Mismatches: %0d", sb.n_mismatch);
    if (sb.n_mismatch == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("ERROR: timeout");
    $display("Verification failed");
    $finish;
  end

endmodule

[year_tagged_day_bitmap_set.f]
+incdir+hdl
hdl/ytdb_pkg.sv
hdl/ytdb_word_store.sv
hdl/year_tagged_day_bitmap_set.sv
tb/sv/year_tagged_day_bitmap_set_tb.sv
